// File: rtl/core/lpkv_pkg.sv
// ----------------------------------------------------------------------------
// lpkv_pkg
// Shared constants, codes and controller/datapath handshake types for the
// linear probing key/value table.
// ----------------------------------------------------------------------------
package lpkv_pkg;

    localparam int SLOTS      = 64;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CUR_W   = IDX_W + 1;
    localparam int ENTRY_W = KEY_BITS + VALUE_BITS;

    localparam int KEY_W      = 64;
    localparam int HOME_W     = 6;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int IN_TDATA_W = 104;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W  = OUT_TDATA_W - STATUS_W - DATA_W;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef struct packed {
        logic                load;
        logic                adv;
        logic                rd;
        logic                wr;
        logic                res_set;
        logic [STATUS_W-1:0] res_status;
        logic                res_hit;
        logic                out_load;
    } lpkv_cmd_t;

    typedef struct packed {
        logic op_read;
        logic in_range;
        logic cur_valid;
        logic cur_end;
        logic key_match;
        logic out_free;
    } lpkv_stat_t;

endpackage

// File: rtl/core/lpkv_ram.sv
// ----------------------------------------------------------------------------
// lpkv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/lpkv_dp.sv
// ----------------------------------------------------------------------------
// lpkv_dp
// Datapath: item registers, probe cursor, slot valid bits, slot RAM, key
// compare, result register and output register.
// ----------------------------------------------------------------------------
module lpkv_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [lpkv_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tuser,
    input  lpkv_pkg::lpkv_cmd_t                cmd,
    output lpkv_pkg::lpkv_stat_t               stat,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lpkv_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    import lpkv_pkg::*;

    logic [KEY_W-1:0]      key_in;
    logic [HOME_W-1:0]     home_in;
    logic [DATA_W-1:0]     data_in;

    logic                  op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CUR_W-1:0]      cur_reg;
    logic                  in_range_reg;
    logic [SLOTS-1:0]      valid_reg;
    logic                  cmp_live_reg;
    logic                  cmp_valid_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [DATA_W-1:0]     res_data_reg;
    logic                  m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic [IDX_W-1:0]      cur_idx;
    logic                  cur_valid;
    logic [ENTRY_W-1:0]    rd_entry;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;

    assign key_in  = s_tdata[KEY_W-1:0];
    assign home_in = s_tdata[KEY_W +: HOME_W];
    assign data_in = s_tdata[KEY_W+HOME_W +: DATA_W];

    assign cur_idx   = cur_reg[IDX_W-1:0];
    assign cur_valid = valid_reg[cur_idx];
    assign rd_key    = rd_entry[ENTRY_W-1 -: KEY_BITS];
    assign rd_value  = rd_entry[VALUE_BITS-1:0];

    lpkv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.wr),
        .waddr (cur_idx),
        .wdata ({key_reg, val_reg}),
        .re    (cmd.rd),
        .raddr (cur_idx),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= s_tuser;
            key_reg      <= key_in[KEY_BITS-1:0];
            val_reg      <= data_in[VALUE_BITS-1:0];
            in_range_reg <= (32'(home_in) < 32'(SLOTS));
        end
        cmp_valid_reg <= cur_valid;
        if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_data_reg   <= cmd.res_hit ? DATA_W'(rd_value) : '0;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {{OUT_PAD_W{1'b0}}, res_data_reg, res_status_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg      <= '0;
            valid_reg    <= '0;
            cmp_live_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                cur_reg <= CUR_W'(home_in);
            end
            else if (cmd.adv)
            begin
                cur_reg <= cur_reg + CUR_W'(1);
            end
            if (cmd.wr)
            begin
                valid_reg[cur_idx] <= 1'b1;
            end
            cmp_live_reg <= cmd.rd;
            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.op_read   = (op_reg == OP_READ);
    assign stat.in_range  = in_range_reg;
    assign stat.cur_valid = cur_valid;
    assign stat.cur_end   = (cur_reg == CUR_W'(SLOTS));
    assign stat.key_match = cmp_live_reg & cmp_valid_reg & (rd_key == key_reg);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: rtl/core/lpkv_ctrl.sv
// ----------------------------------------------------------------------------
// lpkv_ctrl
// Controller: sequences the home-slot check, insert scan and read probe,
// and hands results to the output register.
// ----------------------------------------------------------------------------
module lpkv_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lpkv_pkg::lpkv_stat_t stat,
    output lpkv_pkg::lpkv_cmd_t  cmd
);

    import lpkv_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HOME  = 3'd1;
    localparam logic [2:0] ST_KEY   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_PROBE = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HOME;
                end
            end
            ST_HOME:
            begin
                if (!stat.in_range)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = stat.op_read ? STAT_MISS : STAT_FULL;
                    state_next     = ST_DONE;
                end
                else if (!stat.op_read)
                begin
                    if (!stat.cur_valid)
                    begin
                        cmd.wr         = 1'b1;
                        cmd.res_set    = 1'b1;
                        cmd.res_status = STAT_OK;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        cmd.rd     = 1'b1;
                        state_next = ST_KEY;
                    end
                end
                else if (!stat.cur_valid)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_MISS;
                    state_next     = ST_DONE;
                end
                else
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_KEY:
            begin
                if (stat.key_match)
                begin
                    cmd.wr         = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_OK;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cmd.adv    = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.cur_end)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_FULL;
                    state_next     = ST_DONE;
                end
                else if (!stat.cur_valid)
                begin
                    cmd.wr         = 1'b1;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_OK;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cmd.adv = 1'b1;
                end
            end
            ST_PROBE:
            begin
                if (stat.key_match)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_OK;
                    cmd.res_hit    = 1'b1;
                    state_next     = ST_DONE;
                end
                else if (stat.cur_end)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = STAT_MISS;
                    state_next     = ST_DONE;
                end
                else
                begin
                    cmd.rd  = 1'b1;
                    cmd.adv = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/linear_probe_key_value_table_core.sv
// Throughput: one item at a time, one slot per cycle on the probe; the next
// beat is accepted in the cycle after the result enters the output register.
// Reset: all slot valid bits clear at once; slot key/value RAM is not reset.
// ----------------------------------------------------------------------------
// linear_probe_key_value_table_core
// Key/value table with forward linear probing, insert and read over
// stream channels, one result beat per input beat.
// ----------------------------------------------------------------------------
module linear_probe_key_value_table_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // key[63:0], home_slot[69:64], data_in[101:70], zero pad
    input  logic [lpkv_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], data_out[33:2], zero pad
    output logic [lpkv_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import lpkv_pkg::*;

    lpkv_cmd_t  cmd;
    lpkv_stat_t stat;

    lpkv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpkv_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[STATUS_W-1:0] == STAT_OK ||
                      m_tdata[STATUS_W-1:0] == STAT_FULL ||
                      m_tdata[STATUS_W-1:0] == STAT_MISS))
        else $error("bad status code on output");

    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[STATUS_W-1:0] != STAT_OK)
            |-> (m_tdata[STATUS_W +: DATA_W] == '0))
        else $error("nonzero data on full or miss result");
`endif

endmodule

// File: tb/lpkv_table_checker.sv
// ----------------------------------------------------------------------------
// lpkv_table_checker
// Watches both stream channels of the linear probing key/value table, keeps
// its own copy of the slot table, works out the result of every accepted
// input beat and compares each output beat with the oldest expected result.
// ----------------------------------------------------------------------------
module lpkv_table_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [lpkv_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [lpkv_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                               errors,
    output int                               outstanding,
    output int                               n_stored,
    output int                               n_full,
    output int                               n_hit,
    output int                               n_miss
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpkv_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   data;
    } lookup_result_t;

    logic                  slot_used [SLOTS];
    logic [KEY_BITS-1:0]   slot_key  [SLOTS];
    logic [VALUE_BITS-1:0] slot_val  [SLOTS];

    lookup_result_t expected_q[$];

    function automatic lookup_result_t probe_table(
        input logic              op,
        input logic [KEY_W-1:0]  key_in,
        input logic [HOME_W-1:0] home,
        input logic [DATA_W-1:0] value
    );
        lookup_result_t      r;
        logic [KEY_BITS-1:0] k;
        int                  i;
        bit                  found;
        r.status = STAT_OK;
        r.data   = '0;
        k        = KEY_BITS'(key_in);
        found    = 1'b0;
        if (op == OP_INSERT) begin
            if (int'(home) >= SLOTS) begin
                r.status = STAT_FULL;
            end
            else if (!slot_used[home] || slot_key[home] == k) begin
                slot_used[home] = 1'b1;
                slot_key[home]  = k;
                slot_val[home]  = VALUE_BITS'(value);
            end
            else begin
                r.status = STAT_FULL;
                for (i = int'(home) + 1; i < SLOTS && !found; i++) begin
                    if (!slot_used[i]) begin
                        slot_used[i] = 1'b1;
                        slot_key[i]  = k;
                        slot_val[i]  = VALUE_BITS'(value);
                        r.status     = STAT_OK;
                        found        = 1'b1;
                    end
                end
            end
        end
        else begin
            r.status = STAT_MISS;
            if (int'(home) < SLOTS && slot_used[home]) begin
                for (i = int'(home); i < SLOTS && !found; i++) begin
                    if (slot_used[i] && slot_key[i] == k) begin
                        r.status = STAT_OK;
                        r.data   = DATA_W'(slot_val[i]);
                        found    = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        logic [STATUS_W-1:0] got_status;
        logic [DATA_W-1:0]   got_data;
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++)
                slot_used[i] = 1'b0;
            expected_q.delete();
        end
        else begin
            if (s_tvalid && s_tready) begin
                want = probe_table(s_tuser, s_tdata[KEY_W-1:0],
                                   s_tdata[KEY_W +: HOME_W],
                                   s_tdata[KEY_W+HOME_W +: DATA_W]);
                expected_q.push_back(want);
                if (s_tuser == OP_INSERT) begin
                    if (want.status == STAT_OK) n_stored++;
                    else n_full++;
                end
                else begin
                    if (want.status == STAT_OK) n_hit++;
                    else n_miss++;
                end
            end
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[STATUS_W-1:0];
                got_data   = m_tdata[STATUS_W +: DATA_W];
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, %s %0d data %h",
                             $time, "got status", got_status, got_data);
                    errors++;
                end
                else begin
                    want = expected_q.pop_front();
                    if (got_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got_status);
                        errors++;
                    end
                    if (got_data !== want.data) begin
                        $display("%0t: data_out mismatch, expected %h, got %h",
                                 $time, want.data, got_data);
                        errors++;
                    end
                end
            end
        end
        outstanding = expected_q.size();
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the linear probing key/value table: a directed
// walk through empty, colliding, updating, duplicate and end-of-table cases,
// then random inserts and reads over a pool of random keys plus noise, with
// random idling on both channels, a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpkv_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 1500;
    localparam int KEY_POOL     = 32;
    localparam int HOLD_AT_BEAT = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = SLOTS + 16;
    localparam int LIMIT_CYCLES = 1000000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int errors;
    int outstanding;
    int n_stored;
    int n_full;
    int n_hit;
    int n_miss;
    int beats_sent = 0;
    int cycles = 0;
    bit steady = 1'b0;

    logic [KEY_W-1:0]  pool_key  [KEY_POOL];
    logic [HOME_W-1:0] pool_home [KEY_POOL];

    linear_probe_key_value_table_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lpkv_table_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding),
        .n_stored    (n_stored),
        .n_full      (n_full),
        .n_hit       (n_hit),
        .n_miss      (n_miss)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off while the sender keeps going
    initial
    begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held && beats_sent >= HOLD_AT_BEAT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else begin
                m_tready <= steady || ($urandom_range(99) >= 37);
            end
        end
    end

    task automatic send_item(
        input logic              op,
        input logic [KEY_W-1:0]  key,
        input logic [HOME_W-1:0] home,
        input logic [DATA_W-1:0] value
    );
        while (!steady && $urandom_range(99) < 37) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_TDATA_W-KEY_W-HOME_W-DATA_W){1'b0}}, value, home, key};
        do @(posedge clk); while (!s_tready);
        beats_sent++;
        @(negedge clk);
    endtask

    // hold the input until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        logic [KEY_W-1:0] ka;
        logic [KEY_W-1:0] kb;
        logic [KEY_W-1:0] kc;
        logic [KEY_W-1:0] kd;
        logic [KEY_W-1:0] ke;
        logic [KEY_W-1:0] kf;
        int idx;
        int pick;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = OP_INSERT;
        s_tdata  = '0;
        ka = 64'h0123_4567_89ab_cdef;
        kb = 64'hfedc_ba98_7654_3210;
        kc = 64'h5a5a_5a5a_a5a5_a5a5;
        kd = 64'h0000_0001_0000_0001;
        ke = 64'h7fff_ffff_ffff_fffe;
        kf = 64'h3333_cccc_3333_cccc;
        for (int i = 0; i < KEY_POOL; i++) begin
            pool_key[i]  = {$urandom, $urandom};
            pool_home[i] = HOME_W'($urandom_range(SLOTS - 1));
        end
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(OP_READ,   ka, 6'd5, 32'hdead_beef);
        send_item(OP_INSERT, '0, 6'd0, 32'h0000_0000);
        send_item(OP_READ,   '0, 6'd0, 32'hffff_ffff);
        send_item(OP_INSERT, '1, 6'd63, 32'hffff_ffff);
        send_item(OP_READ,   '1, 6'd63, 32'h0);
        send_item(OP_INSERT, ka, 6'd10, 32'h0000_0011);
        send_item(OP_INSERT, kb, 6'd10, 32'h0000_0022);
        send_item(OP_INSERT, kc, 6'd10, 32'h0000_0033);
        send_item(OP_READ,   kc, 6'd10, 32'h0);
        send_item(OP_INSERT, ka, 6'd10, 32'h0000_0044);
        send_item(OP_READ,   ka, 6'd10, 32'h0);
        send_item(OP_READ,   kb, 6'd12, 32'h0);
        send_item(OP_READ,   kb, 6'd20, 32'h0);
        send_item(OP_INSERT, kf, 6'd14, 32'h0000_00ff);
        send_item(OP_READ,   kf, 6'd12, 32'h0);
        send_item(OP_INSERT, kb, 6'd10, 32'h0000_0055);
        send_item(OP_READ,   kb, 6'd10, 32'h0);
        send_item(OP_INSERT, kd, 6'd62, 32'haaaa_5555);
        send_item(OP_INSERT, ke, 6'd62, 32'h1234_5678);
        send_item(OP_INSERT, ke, 6'd63, 32'h1234_5678);
        send_item(OP_READ,   '1, 6'd62, 32'h0);
        send_item(OP_READ,   ~64'h1, 6'd63, 32'h0);
        send_item(OP_INSERT, 64'h8000_0000_0000_0000, 6'd31, 32'h8000_0000);
        send_item(OP_READ,   64'h8000_0000_0000_0000, 6'd31, 32'h7fff_ffff);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 700 && n < 1000);
            if (n == 1200)
                drain_results();
            pick = $urandom_range(99);
            if (pick < 85) begin
                idx = $urandom_range(KEY_POOL - 1);
                send_item(($urandom_range(99) < 45) ? OP_INSERT : OP_READ,
                          pool_key[idx], pool_home[idx], $urandom);
            end
            else begin
                send_item(($urandom_range(99) < 25) ? OP_INSERT : OP_READ,
                          {$urandom, $urandom}, HOME_W'($urandom_range(SLOTS - 1)),
                          $urandom);
            end
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d beats: %0d inserts stored, %0d inserts full,",
                 beats_sent, n_stored, n_full);
        $display("%0d read hits, %0d read misses; probing covered collisions, %s",
                 n_hit, n_miss, "updates, duplicates and the last slot under stalls");
        if (errors == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: linear_probe_key_value_table_core.f
rtl/core/lpkv_pkg.sv
rtl/core/lpkv_ram.sv
rtl/core/lpkv_dp.sv
rtl/core/lpkv_ctrl.sv
rtl/core/linear_probe_key_value_table_core.sv
tb/lpkv_table_checker.sv
tb/tb.sv
